/* rtl/block_read_ahead_window_cache_core_defines.svh */
// assertion helpers shared by the rtl
`ifndef BLOCK_READ_AHEAD_WINDOW_CACHE_CORE_DEFINES_SVH
`define BLOCK_READ_AHEAD_WINDOW_CACHE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RAWC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RAWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rawc_pkg.sv */
package rawc_pkg;

    localparam int unsigned WINDOW_DEPTH       = 8;
    localparam int unsigned CACHED_BLOCK_BYTES = 512;

    localparam int unsigned LBA_W          = 32;
    localparam int unsigned EXT_W          = LBA_W + 1;
    localparam int unsigned CNT_W          = 16;
    localparam int unsigned SECTOR_BYTES_W = 13;
    localparam int unsigned DEV_W          = 32;
    localparam int unsigned CFG_DATA_W     = 32;
    localparam int unsigned CTR_W          = 32;
    localparam int unsigned HIT_OFF_W      = 3;
    localparam int unsigned CODE_W         = 3;
    localparam int unsigned WIN_CNT_W      = $clog2(WINDOW_DEPTH + 1);

    localparam logic [WIN_CNT_W-1:0]      WIN_DEPTH_CNT    = WIN_CNT_W'(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0]          WIN_DEPTH_REQ    = CNT_W'(WINDOW_DEPTH);
    localparam logic [LBA_W-1:0]          WIN_DEPTH_LBA    = LBA_W'(WINDOW_DEPTH);
    localparam logic [SECTOR_BYTES_W-1:0] CACHED_BS        = SECTOR_BYTES_W'(CACHED_BLOCK_BYTES);
    localparam logic [SECTOR_BYTES_W-1:0] SECTOR_BYTES_RST = SECTOR_BYTES_W'(512);

    typedef enum logic
    {
        REG_SECTOR_BYTES  = 1'b0,
        REG_DEVICE_BLOCKS = 1'b1
    } reg_idx_t;

    typedef enum logic
    {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    typedef enum logic [CODE_W-1:0]
    {
        ST_OK            = 3'd0,
        ST_READ_EMPTY    = 3'd1,
        ST_READ_NO_SIZE  = 3'd2,
        ST_READ_FAILED   = 3'd3,
        ST_WRITE_EMPTY   = 3'd4,
        ST_WRITE_NO_SIZE = 3'd5,
        ST_WRITE_FAILED  = 3'd6
    } status_t;

    typedef enum logic [CODE_W-1:0]
    {
        SRC_NONE         = 3'd0,
        SRC_HIT          = 3'd1,
        SRC_FILL_READ    = 3'd2,
        SRC_DIRECT_READ  = 3'd3,
        SRC_DIRECT_WRITE = 3'd4
    } source_t;

    typedef struct packed
    {
        logic                 valid;
        logic [LBA_W-1:0]     start;
        logic [WIN_CNT_W-1:0] count;
    } win_t;

    localparam win_t WIN_CLEAR = '{valid: 1'b0, start: '0, count: '0};

    typedef struct packed
    {
        win_t             win;
        logic [CTR_W-1:0] hits;
        logic [CTR_W-1:0] misses;
        logic [CTR_W-1:0] fills;
        logic [CTR_W-1:0] invals;
    } cache_state_t;

    typedef struct packed
    {
        cmd_t             cmd;
        logic [LBA_W-1:0] lba;
        logic [CNT_W-1:0] req_blocks;
        logic             storage_ok;
    } req_t;

    typedef struct packed
    {
        status_t              status;
        source_t              source;
        logic [LBA_W-1:0]     access_lba;
        logic [CNT_W-1:0]     access_blocks;
        logic [HIT_OFF_W-1:0] hit_offset;
    } result_t;

endpackage

/* rtl/rawc_decide.sv */
module rawc_decide
    import rawc_pkg::*;
(
    input  req_t                      req,
    input  logic [SECTOR_BYTES_W-1:0] sector_bytes,
    input  logic [DEV_W-1:0]          device_blocks,
    input  cache_state_t              cur,
    output cache_state_t              nxt,
    output result_t                   res
);

    logic                 cached_size;
    logic                 short_req;
    logic [LBA_W-1:0]     offset;
    logic [WIN_CNT_W-1:0] remain;
    logic                 hit;
    logic [LBA_W-1:0]     left;
    logic [WIN_CNT_W-1:0] fill;
    logic                 fill_short;
    logic [EXT_W-1:0]     win_end;
    logic [EXT_W-1:0]     req_end;
    logic                 overlap;

    assign cached_size = (sector_bytes == CACHED_BS);
    assign short_req   = (req.req_blocks <= WIN_DEPTH_REQ);

    // window hit: request lies wholly inside the window
    assign offset = req.lba - cur.win.start;
    assign remain = cur.win.count - offset[WIN_CNT_W-1:0];
    assign hit    = cur.win.valid && (req.lba >= cur.win.start)
                    && (offset <= LBA_W'(cur.win.count))
                    && (req.req_blocks <= CNT_W'(remain));

    // read-ahead length clamped to the end of the device
    assign left       = device_blocks - req.lba;
    assign fill       = (left < WIN_DEPTH_LBA) ? left[WIN_CNT_W-1:0] : WIN_DEPTH_CNT;
    assign fill_short = (CNT_W'(fill) < req.req_blocks);

    // 33-bit ends so a range at the top of the address space does not wrap
    assign win_end = EXT_W'(cur.win.start) + EXT_W'(cur.win.count);
    assign req_end = EXT_W'(req.lba) + EXT_W'(req.req_blocks);
    assign overlap = (EXT_W'(req.lba) < win_end) && (req_end > EXT_W'(cur.win.start));

    always_comb
    begin
        nxt = cur;
        res = '{status: ST_OK, source: SRC_NONE, access_lba: '0,
                access_blocks: '0, hit_offset: '0};
        if (req.cmd == CMD_READ)
        begin
            if (req.req_blocks == '0)
            begin
                res.status = ST_READ_EMPTY;
            end
            else if (sector_bytes == '0)
            begin
                res.status = ST_READ_NO_SIZE;
            end
            else if (cached_size && short_req)
            begin
                if (hit)
                begin
                    nxt.hits       = cur.hits + CTR_W'(1);
                    res.source     = SRC_HIT;
                    res.hit_offset = offset[HIT_OFF_W-1:0];
                end
                else
                begin
                    nxt.misses = cur.misses + CTR_W'(1);
                    if ((req.lba >= device_blocks) || fill_short)
                    begin
                        nxt.win    = WIN_CLEAR;
                        res.status = ST_READ_FAILED;
                    end
                    else
                    begin
                        res.source        = SRC_FILL_READ;
                        res.access_lba    = req.lba;
                        res.access_blocks = CNT_W'(fill);
                        if (!req.storage_ok)
                        begin
                            nxt.win    = WIN_CLEAR;
                            res.status = ST_READ_FAILED;
                        end
                        else
                        begin
                            nxt.win   = '{valid: 1'b1, start: req.lba, count: fill};
                            nxt.fills = cur.fills + CTR_W'(1);
                        end
                    end
                end
            end
            else
            begin
                res.source        = SRC_DIRECT_READ;
                res.access_lba    = req.lba;
                res.access_blocks = req.req_blocks;
                if (!req.storage_ok)
                begin
                    res.status = ST_READ_FAILED;
                end
                else if (cached_size)
                begin
                    // longer than the window, so the window is dropped
                    nxt.win = WIN_CLEAR;
                end
            end
        end
        else
        begin
            if (req.req_blocks == '0)
            begin
                res.status = ST_WRITE_EMPTY;
            end
            else if (sector_bytes == '0)
            begin
                res.status = ST_WRITE_NO_SIZE;
            end
            else
            begin
                if (!cached_size)
                begin
                    nxt.win = WIN_CLEAR;
                end
                else if (cur.win.valid && overlap)
                begin
                    nxt.win    = WIN_CLEAR;
                    nxt.invals = cur.invals + CTR_W'(1);
                end
                res.source        = SRC_DIRECT_WRITE;
                res.access_lba    = req.lba;
                res.access_blocks = req.req_blocks;
                if (!req.storage_ok)
                begin
                    res.status = ST_WRITE_FAILED;
                end
                else if (cached_size)
                begin
                    if (short_req)
                    begin
                        nxt.win   = '{valid: 1'b1, start: req.lba,
                                      count: req.req_blocks[WIN_CNT_W-1:0]};
                        nxt.fills = cur.fills + CTR_W'(1);
                    end
                    else
                    begin
                        nxt.win = WIN_CLEAR;
                    end
                end
            end
        end
    end

endmodule

/* rtl/block_read_ahead_window_cache_core.sv */
// Read-ahead window cache controller for a block store. Each read or write request
// transaction yields exactly one result transaction carrying the status, the store access
// to issue, the window after the request and the hit, miss, fill and invalidation counters.
// A request is captured in an input register, decided in one pass of compare and add logic
// against the window, and lands in a result register that holds it until it is taken; one
// request is accepted every cycle as long as results are taken.
// The input stalls only while its register is full and the result register is held by a
// stalled consumer. Configuration writes take effect at the write edge and are meant to be
// done while no request is in flight.
`include "block_read_ahead_window_cache_core_defines.svh"

module block_read_ahead_window_cache_core
    import rawc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    cmd,
    input  logic [LBA_W-1:0]        lba,
    input  logic [CNT_W-1:0]        req_blocks,
    input  logic                    storage_ok,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [CODE_W-1:0]       status,
    output logic [CODE_W-1:0]       source,
    output logic [LBA_W-1:0]        access_lba,
    output logic [CNT_W-1:0]        access_blocks,
    output logic [HIT_OFF_W-1:0]    hit_offset,
    output logic                    window_valid,
    output logic [LBA_W-1:0]        window_lba,
    output logic [WIN_CNT_W-1:0]    window_blocks,
    output logic [CTR_W-1:0]        hits,
    output logic [CTR_W-1:0]        misses,
    output logic [CTR_W-1:0]        fills,
    output logic [CTR_W-1:0]        invalidations
);

    logic [SECTOR_BYTES_W-1:0] sector_bytes_reg;
    logic [DEV_W-1:0]          device_blocks_reg;

    logic         req_valid_reg;
    logic         req_valid_next;
    req_t         req_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    result_t      res_reg;
    result_t      res_next;
    cache_state_t state_reg;
    cache_state_t state_next;

    logic         accept;
    logic         advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_bytes_reg  <= SECTOR_BYTES_RST;
            device_blocks_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_SECTOR_BYTES:  sector_bytes_reg  <= cfg_data[SECTOR_BYTES_W-1:0];
                REG_DEVICE_BLOCKS: device_blocks_reg <= cfg_data[DEV_W-1:0];
                default:           ;
            endcase
        end
    end

    // the decision stage moves whenever the result register is free or being emptied
    assign advance  = req_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign req_valid_next = accept || (req_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= '{cmd: cmd_t'(cmd), lba: lba, req_blocks: req_blocks,
                         storage_ok: storage_ok};
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    rawc_decide u_decide
    (
        .req           (req_reg),
        .sector_bytes  (sector_bytes_reg),
        .device_blocks (device_blocks_reg),
        .cur           (state_reg),
        .nxt           (state_next),
        .res           (res_next)
    );

    // window and counters move together with the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{win: WIN_CLEAR, hits: '0, misses: '0, fills: '0, invals: '0};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = res_reg.status;
    assign source        = res_reg.source;
    assign access_lba    = res_reg.access_lba;
    assign access_blocks = res_reg.access_blocks;
    assign hit_offset    = res_reg.hit_offset;
    assign window_valid  = state_reg.win.valid;
    assign window_lba    = state_reg.win.start;
    assign window_blocks = state_reg.win.valid ? state_reg.win.count : '0;
    assign hits          = state_reg.hits;
    assign misses        = state_reg.misses;
    assign fills         = state_reg.fills;
    assign invalidations = state_reg.invals;

    `RAWC_ASSERT_NOW(a_invalid_window_empty, !state_reg.win.valid,
        (state_reg.win.count == '0) && (state_reg.win.start == '0),
        "invalid window keeps a start or a count")
    `RAWC_ASSERT_NOW(a_valid_window_size, state_reg.win.valid,
        (state_reg.win.count != '0) && (state_reg.win.count <= WIN_DEPTH_CNT),
        "valid window size out of range")
    `RAWC_ASSERT_NEXT(a_counters_hold, !advance,
        $stable(state_reg.hits) && $stable(state_reg.misses)
        && $stable(state_reg.fills) && $stable(state_reg.invals),
        "counters moved without a decided request")
    `RAWC_ASSERT_NEXT(a_hit_counted, advance && (res_next.source == SRC_HIT),
        state_reg.hits == $past(state_reg.hits) + CTR_W'(1),
        "cache hit not counted")
    `RAWC_ASSERT_NOW(a_hit_no_access, out_valid_reg && (res_reg.source == SRC_HIT),
        (res_reg.status == ST_OK) && (res_reg.access_blocks == '0),
        "cache hit issued a store access")

endmodule
